@@ hw/rtl/cfq_pkg.sv @@
// Shared types and constants for the current fault qualifier.
package cfq_pkg;

	localparam int unsigned SampleWidth = 12;
	localparam int unsigned LevelWidth  = 12;
	localparam int unsigned PersistWidth = 10;
	localparam int unsigned CountWidth  = 11;
	localparam int unsigned CfgIdxWidth = 3;
	localparam int unsigned CfgDataWidth = 12;

	localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

	typedef enum logic [CfgIdxWidth-1:0] {
		REG_TRIP_LEVEL   = 3'd0,
		REG_HOLD_LEVEL   = 3'd1,
		REG_LOSS_LEVEL   = 3'd2,
		REG_TRIP_PERSIST = 3'd3,
		REG_LOSS_PERSIST = 3'd4,
		REG_RESET_SLACK  = 3'd5
	} cfg_reg_t;

	localparam logic [LevelWidth-1:0]   TripLevelRst   = 12'd3724;
	localparam logic [LevelWidth-1:0]   HoldLevelRst   = 12'd2855;
	localparam logic [LevelWidth-1:0]   LossLevelRst   = 12'd148;
	localparam logic [PersistWidth-1:0] TripPersistRst = 10'd850;
	localparam logic [PersistWidth-1:0] LossPersistRst = 10'd50;
	localparam logic [PersistWidth-1:0] ResetSlackRst  = 10'd10;

	typedef struct packed {
		logic [LevelWidth-1:0]   trip_level;
		logic [LevelWidth-1:0]   hold_level;
		logic [LevelWidth-1:0]   loss_level;
		logic [PersistWidth-1:0] trip_persist;
		logic [PersistWidth-1:0] loss_persist;
		logic [PersistWidth-1:0] reset_slack;
	} cfg_t;

	typedef struct packed {
		logic overcurrent_trip;
		logic supply_loss_trip;
		logic stop_drive;
		logic hold_ramp;
		logic show_overcurrent;
		logic show_hold;
		logic show_supply_loss;
	} result_t;

	function automatic logic [CountWidth-1:0] bump(input logic [CountWidth-1:0] c);
		bump = (c < CountMax) ? c + CountWidth'(1) : CountMax;
	endfunction

endpackage

@@ hw/rtl/current_fault_qualifier_core.sv @@
// Current fault qualifier: one sample per cycle through an input register, the persistence
// judgement and a result register. Each transaction is accepted into the input register and
// its result is taken into the result register once that register is free; with the output
// side taking results, a new sample is accepted every cycle. The counters and indications
// update in the same cycle that a sample moves from the input register to the result
// register, so consecutive samples see each other's effect. A stalled output holds the result
// register and a full input register; configuration writes are always taken at once.
module current_fault_qualifier_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [cfq_pkg::SampleWidth-1:0]   sample,
	input  logic                              ramp_active,
	input  logic                              clear_indications,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              overcurrent_trip,
	output logic                              supply_loss_trip,
	output logic                              stop_drive,
	output logic                              hold_ramp,
	output logic                              show_overcurrent,
	output logic                              show_hold,
	output logic                              show_supply_loss,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cfq_pkg::CfgIdxWidth-1:0]   cfg_index,
	input  logic [cfq_pkg::CfgDataWidth-1:0]  cfg_data
);

	cfq_pkg::cfg_t    cfg;
	cfq_pkg::result_t res;
	cfq_pkg::result_t res_s2;

	logic                            valid_s1, valid_s2;
	logic [cfq_pkg::SampleWidth-1:0] sample_s1;
	logic                            ramp_s1, clr_s1;
	logic                            s2_free, advance;

	assign s2_free  = ~valid_s2 | out_ready;
	assign advance  = valid_s1 & s2_free;
	assign in_ready = ~valid_s1 | s2_free;

	cfq_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cfq_judge u_judge (
		.clk               (clk),
		.arst_n            (arst_n),
		.en                (advance),
		.sample            (sample_s1),
		.ramp_active       (ramp_s1),
		.clear_indications (clr_s1),
		.cfg               (cfg),
		.res               (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (s2_free)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= sample;
			ramp_s1   <= ramp_active;
			clr_s1    <= clear_indications;
		end
		if (advance)
			res_s2 <= res;
	end

	assign out_valid        = valid_s2;
	assign overcurrent_trip = res_s2.overcurrent_trip;
	assign supply_loss_trip = res_s2.supply_loss_trip;
	assign stop_drive       = res_s2.stop_drive;
	assign hold_ramp        = res_s2.hold_ramp;
	assign show_overcurrent = res_s2.show_overcurrent;
	assign show_hold        = res_s2.show_hold;
	assign show_supply_loss = res_s2.show_supply_loss;

endmodule

@@ hw/rtl/cfq_cfg_regs.sv @@
// Configuration register file for the current fault qualifier.
module cfq_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cfq_pkg::CfgIdxWidth-1:0]     cfg_index,
	input  logic [cfq_pkg::CfgDataWidth-1:0]    cfg_data,
	output cfq_pkg::cfg_t                       cfg
);

	cfq_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trip_level   <= cfq_pkg::TripLevelRst;
			cfg_q.hold_level   <= cfq_pkg::HoldLevelRst;
			cfg_q.loss_level   <= cfq_pkg::LossLevelRst;
			cfg_q.trip_persist <= cfq_pkg::TripPersistRst;
			cfg_q.loss_persist <= cfq_pkg::LossPersistRst;
			cfg_q.reset_slack  <= cfq_pkg::ResetSlackRst;
		end else if (cfg_valid) begin
			case (cfg_index)
				cfq_pkg::REG_TRIP_LEVEL:   cfg_q.trip_level   <= cfg_data;
				cfq_pkg::REG_HOLD_LEVEL:   cfg_q.hold_level   <= cfg_data;
				cfq_pkg::REG_LOSS_LEVEL:   cfg_q.loss_level   <= cfg_data;
				cfq_pkg::REG_TRIP_PERSIST: cfg_q.trip_persist <= cfg_data[cfq_pkg::PersistWidth-1:0];
				cfq_pkg::REG_LOSS_PERSIST: cfg_q.loss_persist <= cfg_data[cfq_pkg::PersistWidth-1:0];
				cfq_pkg::REG_RESET_SLACK:  cfg_q.reset_slack  <= cfg_data[cfq_pkg::PersistWidth-1:0];
				default: ;
			endcase
		end
	end

endmodule

@@ hw/rtl/cfq_judge.sv @@
// Persistence counters, latched indications and priority resolution.
module cfq_judge (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic [cfq_pkg::SampleWidth-1:0]   sample,
	input  logic                              ramp_active,
	input  logic                              clear_indications,
	input  cfq_pkg::cfg_t                     cfg,
	output cfq_pkg::result_t                  res
);

	localparam int unsigned CW = cfq_pkg::CountWidth;

	logic [CW-1:0] over_count_q, hold_count_q, loss_count_q;
	logic          over_flag_q, hold_flag_q, loss_flag_q;

	logic [CW-1:0] over_count_d, hold_count_d, loss_count_d;
	logic [CW-1:0] over_inc, hold_inc, loss_inc;
	logic [CW-1:0] trip_persist_x, loss_persist_x, slack_x;
	logic          of, hf, lf;
	logic          otrip, ltrip;

	assign trip_persist_x = CW'(cfg.trip_persist);
	assign loss_persist_x = CW'(cfg.loss_persist);
	assign slack_x        = CW'(cfg.reset_slack);
	assign over_inc       = cfq_pkg::bump(over_count_q);
	assign hold_inc       = cfq_pkg::bump(hold_count_q);
	assign loss_inc       = cfq_pkg::bump(loss_count_q);

	always_comb begin
		of           = over_flag_q & ~clear_indications;
		hf           = hold_flag_q & ~clear_indications;
		lf           = loss_flag_q & ~clear_indications;
		otrip        = 1'b0;
		ltrip        = 1'b0;
		over_count_d = over_count_q;
		hold_count_d = hold_count_q;
		loss_count_d = loss_count_q;

		if (sample >= cfg.trip_level) begin
			if (over_inc > trip_persist_x) begin
				over_count_d = '0;
				of           = 1'b1;
				otrip        = 1'b1;
			end else begin
				over_count_d = over_inc;
			end
		end else if (over_count_q > slack_x) begin
			over_count_d = '0;
		end

		if (sample >= cfg.hold_level) begin
			if (hold_inc > trip_persist_x) begin
				hold_count_d = '0;
				hf           = 1'b1;
			end else begin
				hold_count_d = hold_inc;
			end
		end else if (hold_count_q > slack_x) begin
			hold_count_d = '0;
			hf           = 1'b0;
		end

		if (sample <= cfg.loss_level && ramp_active) begin
			if (loss_inc > loss_persist_x) begin
				loss_count_d = '0;
				lf           = 1'b1;
				ltrip        = 1'b1;
			end else begin
				loss_count_d = loss_inc;
			end
		end else if (loss_count_q > slack_x) begin
			loss_count_d = '0;
			lf           = 1'b0;
		end

		// overcurrent > hold > loss, written back into the flags
		priority if (of) begin
			hf = 1'b0;
			lf = 1'b0;
		end else if (hf) begin
			lf = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			over_count_q <= '0;
			hold_count_q <= '0;
			loss_count_q <= '0;
			over_flag_q  <= 1'b0;
			hold_flag_q  <= 1'b0;
			loss_flag_q  <= 1'b0;
		end else if (en) begin
			over_count_q <= over_count_d;
			hold_count_q <= hold_count_d;
			loss_count_q <= loss_count_d;
			over_flag_q  <= of;
			hold_flag_q  <= hf;
			loss_flag_q  <= lf;
		end
	end

	assign res.overcurrent_trip = otrip;
	assign res.supply_loss_trip = ltrip;
	assign res.stop_drive       = otrip | ltrip;
	assign res.hold_ramp        = hf;
	assign res.show_overcurrent = of;
	assign res.show_hold        = hf;
	assign res.show_supply_loss = lf;

endmodule

@@ sim/tb.sv @@
// Testbench for current_fault_qualifier_core: directed and random samples against a predictor.
`timescale 1ns / 100ps

module tb;

	localparam logic [cfq_pkg::CfgIdxWidth-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [cfq_pkg::CfgIdxWidth-1:0] REG_SPARE_HI = 3'd7;
	localparam int STALL_LIMIT = 600;
	localparam int MAX_REPORTS = 10;

	typedef enum int {RUN_OVER, RUN_HOLD, RUN_LOSS, RUN_NOISE} run_kind_t;

	typedef struct packed {
		logic [cfq_pkg::CfgIdxWidth-1:0]  idx;
		logic [cfq_pkg::CfgDataWidth-1:0] data;
	} reg_write_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [cfq_pkg::SampleWidth-1:0] sample;
	logic ramp_active;
	logic clear_indications;
	logic out_valid;
	logic out_ready;
	logic overcurrent_trip;
	logic supply_loss_trip;
	logic stop_drive;
	logic hold_ramp;
	logic show_overcurrent;
	logic show_hold;
	logic show_supply_loss;
	logic cfg_valid;
	logic cfg_ready;
	logic [cfq_pkg::CfgIdxWidth-1:0] cfg_index;
	logic [cfq_pkg::CfgDataWidth-1:0] cfg_data;

	current_fault_qualifier_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.ramp_active(ramp_active),
		.clear_indications(clear_indications),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.overcurrent_trip(overcurrent_trip),
		.supply_loss_trip(supply_loss_trip),
		.stop_drive(stop_drive),
		.hold_ramp(hold_ramp),
		.show_overcurrent(show_overcurrent),
		.show_hold(show_hold),
		.show_supply_loss(show_supply_loss),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	cfq_pkg::cfg_t regs;
	logic [cfq_pkg::CountWidth-1:0] oc_cnt, hold_cnt, loss_cnt;
	logic oc_latched, hold_latched, loss_latched;

	cfq_pkg::result_t expected_results[$];
	reg_write_t pending_writes[$];
	int error_count = 0;
	int report_count = 0;
	int result_index = 0;
	int idle_cycles = 0;
	int hold_off_req = 0;
	bit steady_flow = 1'b0;
	string field_names [7] = '{"overcurrent_trip", "supply_loss_trip", "stop_drive",
		"hold_ramp", "show_overcurrent", "show_hold", "show_supply_loss"};

	function automatic logic [cfq_pkg::CountWidth-1:0] sat_inc(
			input logic [cfq_pkg::CountWidth-1:0] c);
		return (c == {cfq_pkg::CountWidth{1'b1}}) ? c : c + 1'b1;
	endfunction

	function automatic void store_reg(input logic [cfq_pkg::CfgIdxWidth-1:0] idx,
			input logic [cfq_pkg::CfgDataWidth-1:0] data);
		case (cfq_pkg::cfg_reg_t'(idx))
			cfq_pkg::REG_TRIP_LEVEL:   regs.trip_level = data;
			cfq_pkg::REG_HOLD_LEVEL:   regs.hold_level = data;
			cfq_pkg::REG_LOSS_LEVEL:   regs.loss_level = data;
			cfq_pkg::REG_TRIP_PERSIST: regs.trip_persist = data[cfq_pkg::PersistWidth-1:0];
			cfq_pkg::REG_LOSS_PERSIST: regs.loss_persist = data[cfq_pkg::PersistWidth-1:0];
			cfq_pkg::REG_RESET_SLACK:  regs.reset_slack = data[cfq_pkg::PersistWidth-1:0];
			default: ;
		endcase
	endfunction

	function automatic cfq_pkg::result_t judge_sample(input logic [cfq_pkg::SampleWidth-1:0] s,
			input logic ramp, input logic clr);
		cfq_pkg::result_t r;
		logic oc_fire, loss_fire;
		oc_fire = 1'b0;
		loss_fire = 1'b0;
		if (clr) begin
			oc_latched = 1'b0;
			hold_latched = 1'b0;
			loss_latched = 1'b0;
		end
		if (s >= regs.trip_level) begin
			oc_cnt = sat_inc(oc_cnt);
			if (oc_cnt > regs.trip_persist) begin
				oc_cnt = '0;
				oc_latched = 1'b1;
				oc_fire = 1'b1;
			end
		end else if (oc_cnt > regs.reset_slack) begin
			oc_cnt = '0;
		end
		if (s >= regs.hold_level) begin
			hold_cnt = sat_inc(hold_cnt);
			if (hold_cnt > regs.trip_persist) begin
				hold_cnt = '0;
				hold_latched = 1'b1;
			end
		end else if (hold_cnt > regs.reset_slack) begin
			hold_cnt = '0;
			hold_latched = 1'b0;
		end
		if (s <= regs.loss_level && ramp) begin
			loss_cnt = sat_inc(loss_cnt);
			if (loss_cnt > regs.loss_persist) begin
				loss_cnt = '0;
				loss_latched = 1'b1;
				loss_fire = 1'b1;
			end
		end else if (loss_cnt > regs.reset_slack) begin
			loss_cnt = '0;
			loss_latched = 1'b0;
		end
		// overcurrent > hold > loss, written back
		if (oc_latched) begin
			hold_latched = 1'b0;
			loss_latched = 1'b0;
		end else if (hold_latched) begin
			loss_latched = 1'b0;
		end
		r.overcurrent_trip = oc_fire;
		r.supply_loss_trip = loss_fire;
		r.stop_drive = oc_fire | loss_fire;
		r.hold_ramp = hold_latched;
		r.show_overcurrent = oc_latched;
		r.show_hold = hold_latched;
		r.show_supply_loss = loss_latched;
		return r;
	endfunction

	function automatic int draw_gap();
		if (steady_flow)
			return 0;
		return $urandom_range(0, 14);
	endfunction

	task automatic send_sample(input logic [cfq_pkg::SampleWidth-1:0] s, input logic ramp,
			input logic clr);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		ramp_active <= ramp;
		clear_indications <= clr;
		@(posedge clk);
		while (!(in_valid && in_ready))
			@(posedge clk);
		expected_results.push_back(judge_sample(s, ramp, clr));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		if (in_valid)
			in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic queue_write(input logic [cfq_pkg::CfgIdxWidth-1:0] idx,
			input logic [cfq_pkg::CfgDataWidth-1:0] data);
		reg_write_t w;
		w.idx = idx;
		w.data = data;
		pending_writes.push_back(w);
	endtask

	// block must be idle when called
	task automatic flush_writes();
		reg_write_t w;
		while (pending_writes.size() != 0) begin
			w = pending_writes.pop_front();
			cfg_valid <= 1'b1;
			cfg_index <= w.idx;
			cfg_data <= w.data;
			@(posedge clk);
			while (!(cfg_valid && cfg_ready))
				@(posedge clk);
			store_reg(w.idx, w.data);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic send_run(input run_kind_t kind, input int len);
		int lo, hi, s;
		logic ramp;
		for (int k = 0; k < len; k++) begin
			case (kind)
				RUN_OVER: begin
					lo = int'(regs.trip_level);
					hi = 4095;
				end
				RUN_HOLD: begin
					lo = int'(regs.hold_level);
					hi = (regs.trip_level > regs.hold_level) ? int'(regs.trip_level) - 1 : 4095;
				end
				RUN_LOSS: begin
					lo = 0;
					hi = int'(regs.loss_level);
				end
				default: begin
					lo = 0;
					hi = 4095;
				end
			endcase
			s = $urandom_range(hi, lo);
			ramp = (kind == RUN_LOSS) ? ($urandom_range(0, 7) != 0) : 1'($urandom_range(0, 1));
			// break the sequence now and then
			if ($urandom_range(0, 9) == 0)
				s = $urandom_range(0, 4095);
			send_sample(s[cfq_pkg::SampleWidth-1:0], ramp, $urandom_range(0, 19) == 0);
		end
	endtask

	task automatic test_reset_defaults();
		send_sample(12'd0, 1'b1, 1'b0);
		send_sample(12'd4095, 1'b0, 1'b1);
		send_sample(12'd148, 1'b1, 1'b0);
		send_sample(12'd149, 1'b1, 1'b0);
		send_sample(12'd3724, 1'b0, 1'b0);
		send_sample(12'd3723, 1'b1, 1'b0);
		send_sample(12'd2855, 1'b0, 1'b0);
		send_sample(12'd2854, 1'b1, 1'b1);
		wait_drained();
	endtask

	task automatic test_priority();
		queue_write(cfq_pkg::REG_TRIP_PERSIST, 12'd0);
		queue_write(cfq_pkg::REG_LOSS_PERSIST, 12'd0);
		queue_write(cfq_pkg::REG_RESET_SLACK, 12'd0);
		flush_writes();
		send_sample(12'd0, 1'b1, 1'b0);
		send_sample(12'd2900, 1'b0, 1'b0);
		send_sample(12'd4095, 1'b1, 1'b0);
		// overcurrent stays latched through a loss sample; a cleared quiet sample drops it, then it trips again
		send_sample(12'd0, 1'b1, 1'b0);
		send_sample(12'd2000, 1'b0, 1'b1);
		send_sample(12'd4095, 1'b1, 1'b1);
		wait_drained();
		// both trips on one tick
		queue_write(cfq_pkg::REG_TRIP_LEVEL, 12'd100);
		queue_write(cfq_pkg::REG_LOSS_LEVEL, 12'd200);
		flush_writes();
		send_sample(12'd150, 1'b1, 1'b0);
		wait_drained();
	endtask

	task automatic test_limit_below_count();
		queue_write(cfq_pkg::REG_TRIP_LEVEL, cfq_pkg::TripLevelRst);
		queue_write(cfq_pkg::REG_LOSS_LEVEL, cfq_pkg::LossLevelRst);
		queue_write(cfq_pkg::REG_TRIP_PERSIST, 12'd20);
		queue_write(cfq_pkg::REG_RESET_SLACK, 12'hFFF);
		flush_writes();
		repeat (5) send_sample(12'd4000, 1'b0, 1'b0);
		wait_drained();
		queue_write(REG_SPARE_LO, 12'h000);
		queue_write(REG_SPARE_HI, 12'hFFF);
		queue_write(cfq_pkg::REG_TRIP_PERSIST, 12'hC02);
		flush_writes();
		send_sample(12'd4000, 1'b0, 1'b0);
		send_sample(12'd2000, 1'b0, 1'b0);
		wait_drained();
	endtask

	task automatic test_long_persistence();
		queue_write(cfq_pkg::REG_TRIP_LEVEL, 12'd0);
		queue_write(cfq_pkg::REG_HOLD_LEVEL, 12'd0);
		queue_write(cfq_pkg::REG_LOSS_LEVEL, 12'd4095);
		queue_write(cfq_pkg::REG_TRIP_PERSIST, 12'hDFF);
		queue_write(cfq_pkg::REG_LOSS_PERSIST, 12'h7FF);
		queue_write(cfq_pkg::REG_RESET_SLACK, 12'h3FF);
		flush_writes();
		repeat (520)
			send_sample(12'($urandom_range(0, 4095)), 1'b1, $urandom_range(0, 63) == 0);
		wait_drained();
	endtask

	task automatic test_receiver_hold_off();
		queue_write(cfq_pkg::REG_TRIP_LEVEL, cfq_pkg::TripLevelRst);
		queue_write(cfq_pkg::REG_HOLD_LEVEL, cfq_pkg::HoldLevelRst);
		queue_write(cfq_pkg::REG_LOSS_LEVEL, cfq_pkg::LossLevelRst);
		queue_write(cfq_pkg::REG_TRIP_PERSIST, 12'd3);
		queue_write(cfq_pkg::REG_LOSS_PERSIST, 12'd2);
		queue_write(cfq_pkg::REG_RESET_SLACK, 12'd1);
		flush_writes();
		hold_off_req = 80;
		send_run(RUN_OVER, 15);
		send_run(RUN_LOSS, 15);
		// sender waits for every result before going on
		wait_drained();
		send_run(RUN_HOLD, 10);
		wait_drained();
	endtask

	task automatic test_random_phases();
		int loss_lv, hold_lv, trip_lv, sent, len;
		for (int phase = 0; phase < 5; phase++) begin
			if ($urandom_range(0, 2) != 0) begin
				loss_lv = $urandom_range(0, 1500);
				hold_lv = $urandom_range(loss_lv + 1, 3500);
				trip_lv = $urandom_range(hold_lv + 1, 4095);
			end else begin
				loss_lv = ($urandom_range(0, 2) == 0) ? 4095 : $urandom_range(0, 4095);
				hold_lv = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4095);
				trip_lv = ($urandom_range(0, 2) == 0) ? 4095 : $urandom_range(0, 4095);
			end
			queue_write(cfq_pkg::REG_TRIP_LEVEL, 12'(trip_lv));
			queue_write(cfq_pkg::REG_HOLD_LEVEL, 12'(hold_lv));
			queue_write(cfq_pkg::REG_LOSS_LEVEL, 12'(loss_lv));
			for (int r = 0; r < 3; r++) begin
				case ($urandom_range(0, 7))
					0: len = 0;
					1: len = 1023;
					default: len = $urandom_range(0, 12);
				endcase
				queue_write(r == 0 ? cfq_pkg::REG_TRIP_PERSIST :
					r == 1 ? cfq_pkg::REG_LOSS_PERSIST : cfq_pkg::REG_RESET_SLACK,
					{2'($urandom_range(0, 3)), 10'(len)});
			end
			if ($urandom_range(0, 2) == 0)
				queue_write($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
					12'($urandom_range(0, 4095)));
			flush_writes();
			steady_flow = ($urandom_range(0, 3) == 0);
			sent = 0;
			while (sent < 80) begin
				len = $urandom_range(1, 30);
				send_run(run_kind_t'($urandom_range(0, 3)), len);
				sent += len;
				if ($urandom_range(0, 7) == 0)
					wait_drained();
			end
			wait_drained();
		end
		steady_flow = 1'b0;
	endtask

	// result side: random back-pressure, long hold-off on request
	initial begin
		int wait_cycles;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			wait_cycles = draw_gap();
			if (hold_off_req > 0) begin
				wait_cycles = hold_off_req;
				hold_off_req = 0;
			end
			if (wait_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (wait_cycles) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!(out_valid && out_ready))
				@(posedge clk);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin : check_results
		cfq_pkg::result_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = {overcurrent_trip, supply_loss_trip, stop_drive, hold_ramp,
				show_overcurrent, show_hold, show_supply_loss};
			if (expected_results.size() == 0) begin
				error_count++;
				if (report_count < MAX_REPORTS)
					$display("result %0d arrived with none expected: %b", result_index, got);
				report_count++;
			end else begin
				want = expected_results.pop_front();
				for (int i = 0; i < 7; i++) begin
					if (got[6-i] !== want[6-i]) begin
						error_count++;
						if (report_count < MAX_REPORTS)
							$display("result %0d %s: expected %b, got %b", result_index,
								field_names[i], want[6-i], got[6-i]);
						report_count++;
					end
				end
			end
			result_index++;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		ramp_active = 1'b0;
		clear_indications = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		regs.trip_level = cfq_pkg::TripLevelRst;
		regs.hold_level = cfq_pkg::HoldLevelRst;
		regs.loss_level = cfq_pkg::LossLevelRst;
		regs.trip_persist = cfq_pkg::TripPersistRst;
		regs.loss_persist = cfq_pkg::LossPersistRst;
		regs.reset_slack = cfq_pkg::ResetSlackRst;
		oc_cnt = '0;
		hold_cnt = '0;
		loss_cnt = '0;
		oc_latched = 1'b0;
		hold_latched = 1'b0;
		loss_latched = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_priority();
		test_limit_below_count();
		test_long_persistence();
		test_receiver_hold_off();
		test_random_phases();
		wait_drained();
		repeat (8) @(negedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
